// ----- design/i2cbb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Shared types for the I2C bit sequencer: command and status codes, the
// command and result transaction structs, and the configuration set.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

  // Command codes carried by one transaction
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_ACK   = 3'd3,
    CMD_NACK  = 3'd4,
    CMD_WACK  = 3'd5,
    CMD_WRITE = 3'd6,
    CMD_READ  = 3'd7
  } cmd_t;

  // Completion status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BUS_BUSY = 2'd1,
    ST_START_ER = 2'd2,
    ST_NO_ACK   = 2'd3
  } status_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'd1;

  typedef struct packed {
    logic [7:0] phase_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    cmd_t       func;
    logic [7:0] tx_byte;
    logic       msb_first;
    logic       sda_in;
  } cmd_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    status_t    status;
  } res_item_t;

endpackage
`default_nettype wire

// ----- design/i2c_bitbang_master_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_bitbang_master_unit
// I2C master bit sequencer. Each command transaction is one tick: it may
// start a command when idle and advances the SCL/SDA phase sequence.
// ----------------------------------------------------------------------------
//  channel   direction  signals                         carries
//  cmd       in         cmd_valid / cmd_ready / cmd     one tick: func, tx, sda
//  res       out        res_valid / res_ready / res     line drive and status
//  cfg       in         cfg_we / cfg_index / cfg_data   phase_ticks, ack_timeout
//
//  One transaction per cycle while the result register has space; its result
//  is registered there at acceptance, formed by the single next-state pass.
//  cmd_ready drops only while a held result is not taken.
//  Reset (rst, synchronous) idles the sequencer and releases both lines.
// ----------------------------------------------------------------------------
module i2c_bitbang_master_unit (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cmd_valid,
  output logic                                  cmd_ready,
  input  i2cbb_pkg::cmd_item_t                  cmd,
  output logic                                  res_valid,
  input  wire                                   res_ready,
  output i2cbb_pkg::res_item_t                  res,
  input  wire                                   cfg_we,
  input  wire  [i2cbb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [i2cbb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  i2cbb_pkg::cfg_t      cfg;
  i2cbb_pkg::res_item_t core_res;
  logic                 accept;

  assign accept = cmd_valid && cmd_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_ticks <= 8'd4;
      cfg.ack_timeout <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cbb_pkg::REG_PHASE_TICKS: cfg.phase_ticks <= cfg_data;
        i2cbb_pkg::REG_ACK_TIMEOUT: cfg.ack_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  i2cbb_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .cmd    (cmd),
    .result (core_res)
  );

  i2cbb_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .din       (core_res),
    .space     (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
`default_nettype wire

// ----- design/i2cbb_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbb_core
// Bit sequencer state and the one-pass next-state logic. Each accepted
// transaction is one tick; the state advances and the result is formed.
// ----------------------------------------------------------------------------
module i2cbb_core (
  input  wire                   clk,
  input  wire                   rst,
  input  i2cbb_pkg::cfg_t       cfg,
  input  wire                   accept,
  input  i2cbb_pkg::cmd_item_t  cmd,
  output i2cbb_pkg::res_item_t  result
);

  typedef enum logic [1:0] {
    PH_LOW  = 2'd0,
    PH_HIGH = 2'd1,
    PH_POLL = 2'd2
  } phase_t;

  i2cbb_pkg::cmd_t operation, operation_next;
  phase_t          phase, phase_next;
  logic [3:0]      bit_index, bit_index_next;
  logic [7:0]      shift_reg, shift_reg_next;
  logic [7:0]      tick_count, tick_count_next;
  logic [7:0]      poll_count, poll_count_next;
  logic            scl_line, scl_line_next;
  logic            sda_line, sda_line_next;
  logic            bit_order, bit_order_next;
  logic [7:0]      rx_last, rx_last_next;

  logic               fin;
  i2cbb_pkg::status_t fin_status;
  logic [7:0]         pt;
  logic [7:0]         lim;
  logic [3:0]         bit_inc;
  logic [7:0]         rd_shift;
  logic [7:0]         poll_inc;

  // Zero in either register acts as one
  assign pt  = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
  assign lim = (cfg.ack_timeout == 8'd0) ? 8'd1 : cfg.ack_timeout;

  assign bit_inc  = bit_index + 4'd1;
  assign rd_shift = {cmd.sda_in, shift_reg[7:1]};
  assign poll_inc = (poll_count < 8'd255) ? poll_count + 8'd1 : poll_count;

  // Advance the sequencer by one tick
  always_comb begin
    operation_next  = operation;
    phase_next      = phase;
    bit_index_next  = bit_index;
    shift_reg_next  = shift_reg;
    tick_count_next = tick_count;
    poll_count_next = poll_count;
    scl_line_next   = scl_line;
    sda_line_next   = sda_line;
    bit_order_next  = bit_order;
    rx_last_next    = rx_last;
    fin             = 1'b0;
    fin_status      = i2cbb_pkg::ST_OK;

    if (operation == i2cbb_pkg::CMD_NONE) begin
      // Idle: take a new command; the accept tick opens the first phase
      if (cmd.func != i2cbb_pkg::CMD_NONE) begin
        operation_next  = cmd.func;
        bit_index_next  = 4'd0;
        poll_count_next = 8'd0;
        phase_next      = PH_LOW;
        tick_count_next = 8'd1;
        case (cmd.func)
          i2cbb_pkg::CMD_START: begin
            scl_line_next = 1'b1;
            sda_line_next = 1'b1;
          end
          i2cbb_pkg::CMD_STOP, i2cbb_pkg::CMD_ACK: begin
            scl_line_next = 1'b0;
            sda_line_next = 1'b0;
          end
          i2cbb_pkg::CMD_WRITE: begin
            bit_order_next = cmd.msb_first;
            scl_line_next  = 1'b0;
            if (cmd.msb_first) begin
              sda_line_next  = cmd.tx_byte[7];
              shift_reg_next = {cmd.tx_byte[6:0], 1'b0};
            end else begin
              sda_line_next  = cmd.tx_byte[0];
              shift_reg_next = {1'b0, cmd.tx_byte[7:1]};
            end
          end
          i2cbb_pkg::CMD_READ: begin
            shift_reg_next = 8'd0;
            scl_line_next  = 1'b0;
            sda_line_next  = 1'b1;
          end
          default: begin
            // nack and wait-ack: SCL low, SDA released
            scl_line_next = 1'b0;
            sda_line_next = 1'b1;
          end
        endcase
      end
    end else if (operation == i2cbb_pkg::CMD_WACK && phase == PH_POLL) begin
      // Poll SDA once per tick
      poll_count_next = poll_inc;
      if (!cmd.sda_in) begin
        scl_line_next  = 1'b0;
        sda_line_next  = 1'b1;
        operation_next = i2cbb_pkg::CMD_NONE;
        phase_next     = PH_LOW;
        fin            = 1'b1;
      end else if (poll_inc >= lim) begin
        scl_line_next  = 1'b0;
        sda_line_next  = 1'b1;
        operation_next = i2cbb_pkg::CMD_NONE;
        phase_next     = PH_LOW;
        fin            = 1'b1;
        fin_status     = i2cbb_pkg::ST_NO_ACK;
      end
    end else if (tick_count < pt) begin
      tick_count_next = tick_count + 8'd1;
    end else begin
      // End of a phase
      tick_count_next = 8'd1;
      case (operation)
        i2cbb_pkg::CMD_START: begin
          if (phase == PH_LOW) begin
            if (!cmd.sda_in) begin
              fin        = 1'b1;
              fin_status = i2cbb_pkg::ST_BUS_BUSY;
            end else begin
              phase_next    = PH_HIGH;
              scl_line_next = 1'b1;
              sda_line_next = 1'b0;
            end
          end else if (phase == PH_HIGH) begin
            if (cmd.sda_in) begin
              fin        = 1'b1;
              fin_status = i2cbb_pkg::ST_START_ER;
            end else begin
              phase_next    = PH_POLL;
              scl_line_next = 1'b0;
              sda_line_next = 1'b0;
            end
          end else begin
            fin = 1'b1;
          end
        end
        i2cbb_pkg::CMD_STOP: begin
          if (phase == PH_LOW) begin
            phase_next    = PH_HIGH;
            scl_line_next = 1'b1;
            sda_line_next = 1'b0;
          end else begin
            scl_line_next = 1'b1;
            sda_line_next = 1'b1;
            fin           = 1'b1;
          end
        end
        i2cbb_pkg::CMD_WACK: begin
          if (phase == PH_LOW) begin
            phase_next    = PH_HIGH;
            scl_line_next = 1'b1;
            sda_line_next = 1'b1;
          end else begin
            // First poll at the end of the high phase
            poll_count_next = 8'd1;
            if (!cmd.sda_in) begin
              scl_line_next = 1'b0;
              sda_line_next = 1'b1;
              fin           = 1'b1;
            end else if (lim <= 8'd1) begin
              scl_line_next = 1'b0;
              sda_line_next = 1'b1;
              fin           = 1'b1;
              fin_status    = i2cbb_pkg::ST_NO_ACK;
            end else begin
              phase_next = PH_POLL;
            end
          end
        end
        i2cbb_pkg::CMD_WRITE: begin
          if (phase == PH_LOW) begin
            phase_next    = PH_HIGH;
            scl_line_next = 1'b1;
          end else begin
            bit_index_next = bit_inc;
            if (bit_inc >= 4'd8) begin
              scl_line_next = 1'b0;
              fin           = 1'b1;
            end else begin
              phase_next    = PH_LOW;
              scl_line_next = 1'b0;
              if (bit_order) begin
                sda_line_next  = shift_reg[7];
                shift_reg_next = {shift_reg[6:0], 1'b0};
              end else begin
                sda_line_next  = shift_reg[0];
                shift_reg_next = {1'b0, shift_reg[7:1]};
              end
            end
          end
        end
        i2cbb_pkg::CMD_READ: begin
          if (phase == PH_LOW) begin
            phase_next    = PH_HIGH;
            scl_line_next = 1'b1;
            sda_line_next = 1'b1;
          end else begin
            shift_reg_next = rd_shift;
            bit_index_next = bit_inc;
            scl_line_next  = 1'b0;
            sda_line_next  = 1'b1;
            if (bit_inc >= 4'd8) begin
              rx_last_next = rd_shift;
              fin          = 1'b1;
            end else begin
              phase_next = PH_LOW;
            end
          end
        end
        default: begin
          // ack and nack: SCL high, then low at the end
          if (phase == PH_LOW) begin
            phase_next    = PH_HIGH;
            scl_line_next = 1'b1;
          end else begin
            scl_line_next = 1'b0;
            fin           = 1'b1;
          end
        end
      endcase
      if (fin) begin
        operation_next = i2cbb_pkg::CMD_NONE;
        phase_next     = PH_LOW;
        tick_count_next = tick_count;
      end
    end
  end

  // Form the result of this tick
  always_comb begin
    result.scl_out  = scl_line_next;
    result.sda_out  = sda_line_next;
    result.busy_res = (operation_next != i2cbb_pkg::CMD_NONE);
    result.done_res = fin;
    result.rx_byte  = rx_last_next;
    result.status   = fin ? fin_status : i2cbb_pkg::ST_OK;
  end

  // Hold sequencer state; advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      operation  <= i2cbb_pkg::CMD_NONE;
      phase      <= PH_LOW;
      bit_index  <= 4'd0;
      shift_reg  <= 8'd0;
      tick_count <= 8'd0;
      poll_count <= 8'd0;
      scl_line   <= 1'b1;
      sda_line   <= 1'b1;
      bit_order  <= 1'b1;
      rx_last    <= 8'd0;
    end else if (accept) begin
      operation  <= operation_next;
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      shift_reg  <= shift_reg_next;
      tick_count <= tick_count_next;
      poll_count <= poll_count_next;
      scl_line   <= scl_line_next;
      sda_line   <= sda_line_next;
      bit_order  <= bit_order_next;
      rx_last    <= rx_last_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/i2cbb_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbb_out_reg
// Result register: holds one result transaction until the consumer takes
// it, and lets a new one load in the same cycle as the old one leaves.
// ----------------------------------------------------------------------------
module i2cbb_out_reg (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   load,
  input  i2cbb_pkg::res_item_t  din,
  output logic                  space,
  output logic                  res_valid,
  input  wire                   res_ready,
  output i2cbb_pkg::res_item_t  res
);

  // Accept upstream when empty or when the held result leaves now
  assign space = !res_valid || res_ready;

  // Hold valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Load payload
  always_ff @(posedge clk) begin
    if (load) begin
      res <= din;
    end
  end

endmodule
`default_nettype wire

// ----- design/i2cbb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbb_checker
// Port-level checks on the sequencer: stall behavior, command flow and
// consistency of the result flags.
// ----------------------------------------------------------------------------
module i2cbb_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  cmd_ready,
  input wire                  res_valid,
  input wire                  res_ready,
  input i2cbb_pkg::res_item_t res
);

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // Commands flow whenever no result waits
  a_cmd_flow: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cmd_ready)
    else $error("command channel blocked with empty result register");

  // Finished command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |-> !res.busy_res)
    else $error("done reported while still busy");

  // Status is zero unless a command finished
  a_status_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.done_res |-> res.status == i2cbb_pkg::ST_OK)
    else $error("status set without done");

endmodule

bind i2c_bitbang_master_unit i2cbb_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
`default_nettype wire

// ----- tb/i2c_bitbang_master_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bitbang_master_unit_test
// Tick-by-tick check of the I2C bit sequencer. Every command transaction is
// mirrored by a cycle-exact model of the SCL/SDA phase sequence, and each
// result transaction is compared field by field with the model's prediction.
// Directed commands and register extremes are followed by randomized bus
// transfers with random stalls on both channels.
// ----------------------------------------------------------------------------
module i2c_bitbang_master_unit_test;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 48;

  // How the testbench plays the SDA line seen by the master
  typedef enum {BUS_LOOP, BUS_NOISY, BUS_LOW, BUS_HIGH, BUS_RAND} bus_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  i2cbb_pkg::cmd_item_t cmd;
  logic res_valid;
  logic res_ready;
  i2cbb_pkg::res_item_t res;
  logic cfg_we;
  logic [i2cbb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [i2cbb_pkg::CFG_DATA_W-1:0] cfg_data;

  // Sequencer model state
  logic [7:0] cfg_ticks, cfg_timeout;
  i2cbb_pkg::cmd_t seq_op;
  logic [2:0] seq_phase;
  logic [3:0] seq_bit;
  logic [7:0] seq_shift, seq_tick, seq_poll, seq_rx;
  logic seq_scl, seq_sda, seq_msb, seq_done;
  i2cbb_pkg::status_t seq_status;

  i2cbb_pkg::res_item_t pending_drive[$];
  int unsigned n_fail = 0;
  int unsigned n_ticks = 0;
  int unsigned cycle_count = 0;
  logic [7:0] slave_delay;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;

  i2c_bitbang_master_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer model
  // ---------------------------------------------------------------------------
  function automatic void model_reset();
    cfg_ticks = 8'd4;
    cfg_timeout = 8'd255;
    seq_op = i2cbb_pkg::CMD_NONE;
    seq_phase = '0;
    seq_bit = '0;
    seq_shift = '0;
    seq_tick = '0;
    seq_poll = '0;
    seq_scl = 1'b1;
    seq_sda = 1'b1;
    seq_msb = 1'b1;
    seq_rx = '0;
  endfunction

  function automatic void seq_enter(logic [2:0] ph, logic scl, logic sda);
    seq_phase = ph;
    seq_scl = scl;
    seq_sda = sda;
    seq_tick = 8'd1;
  endfunction

  function automatic void seq_end(i2cbb_pkg::status_t st);
    seq_op = i2cbb_pkg::CMD_NONE;
    seq_phase = '0;
    seq_done = 1'b1;
    seq_status = st;
  endfunction

  function automatic logic shift_out_bit();
    logic b;
    if (seq_msb) begin
      b = seq_shift[7];
      seq_shift = seq_shift << 1;
    end else begin
      b = seq_shift[0];
      seq_shift = seq_shift >> 1;
    end
    return b;
  endfunction

  // One SDA poll of the acknowledge wait; release SCL low on either outcome
  function automatic void ack_poll(logic sda);
    logic [7:0] lim;
    lim = (cfg_timeout == 8'd0) ? 8'd1 : cfg_timeout;
    if (!sda) begin
      seq_scl = 1'b0;
      seq_sda = 1'b1;
      seq_end(i2cbb_pkg::ST_OK);
    end else if (seq_poll >= lim) begin
      seq_scl = 1'b0;
      seq_sda = 1'b1;
      seq_end(i2cbb_pkg::ST_NO_ACK);
    end else begin
      seq_phase = 3'd2;
    end
  endfunction

  // Advance the model by one tick and return the line drive after it
  function automatic i2cbb_pkg::res_item_t i2c_tick(i2cbb_pkg::cmd_item_t c);
    i2cbb_pkg::res_item_t r;
    logic [7:0] pt;
    pt = (cfg_ticks == 8'd0) ? 8'd1 : cfg_ticks;
    seq_done = 1'b0;
    seq_status = i2cbb_pkg::ST_OK;
    if (seq_op == i2cbb_pkg::CMD_NONE) begin
      if (c.func != i2cbb_pkg::CMD_NONE) begin
        seq_op = c.func;
        seq_bit = '0;
        seq_poll = '0;
        case (c.func)
          i2cbb_pkg::CMD_START: seq_enter(3'd0, 1'b1, 1'b1);
          i2cbb_pkg::CMD_STOP, i2cbb_pkg::CMD_ACK: seq_enter(3'd0, 1'b0, 1'b0);
          i2cbb_pkg::CMD_NACK, i2cbb_pkg::CMD_WACK: seq_enter(3'd0, 1'b0, 1'b1);
          i2cbb_pkg::CMD_WRITE: begin
            seq_shift = c.tx_byte;
            seq_msb = c.msb_first;
            seq_enter(3'd0, 1'b0, shift_out_bit());
          end
          default: begin
            seq_shift = '0;
            seq_enter(3'd0, 1'b0, 1'b1);
          end
        endcase
      end
    end else if (seq_op == i2cbb_pkg::CMD_WACK && seq_phase == 3'd2) begin
      if (seq_poll < 8'd255) seq_poll++;
      ack_poll(c.sda_in);
    end else if (seq_tick < pt) begin
      seq_tick++;
    end else begin
      // End of a phase: sample SDA and move on
      case (seq_op)
        i2cbb_pkg::CMD_START: begin
          if (seq_phase == 3'd0) begin
            if (!c.sda_in) seq_end(i2cbb_pkg::ST_BUS_BUSY);
            else seq_enter(3'd1, 1'b1, 1'b0);
          end else if (seq_phase == 3'd1) begin
            if (c.sda_in) seq_end(i2cbb_pkg::ST_START_ER);
            else seq_enter(3'd2, 1'b0, 1'b0);
          end else begin
            seq_end(i2cbb_pkg::ST_OK);
          end
        end
        i2cbb_pkg::CMD_STOP: begin
          if (seq_phase == 3'd0) begin
            seq_enter(3'd1, 1'b1, 1'b0);
          end else begin
            seq_scl = 1'b1;
            seq_sda = 1'b1;
            seq_end(i2cbb_pkg::ST_OK);
          end
        end
        i2cbb_pkg::CMD_ACK, i2cbb_pkg::CMD_NACK: begin
          if (seq_phase == 3'd0) begin
            seq_enter(3'd1, 1'b1, seq_sda);
          end else begin
            seq_scl = 1'b0;
            seq_end(i2cbb_pkg::ST_OK);
          end
        end
        i2cbb_pkg::CMD_WACK: begin
          if (seq_phase == 3'd0) begin
            seq_enter(3'd1, 1'b1, 1'b1);
          end else begin
            seq_poll = 8'd1;
            ack_poll(c.sda_in);
          end
        end
        i2cbb_pkg::CMD_WRITE: begin
          if (seq_phase == 3'd0) begin
            seq_enter(3'd1, 1'b1, seq_sda);
          end else begin
            seq_bit++;
            if (seq_bit >= 4'd8) begin
              seq_scl = 1'b0;
              seq_end(i2cbb_pkg::ST_OK);
            end else begin
              seq_enter(3'd0, 1'b0, shift_out_bit());
            end
          end
        end
        i2cbb_pkg::CMD_READ: begin
          if (seq_phase == 3'd0) begin
            seq_enter(3'd1, 1'b1, 1'b1);
          end else begin
            seq_shift = {c.sda_in, seq_shift[7:1]};
            seq_bit++;
            if (seq_bit >= 4'd8) begin
              seq_rx = seq_shift;
              seq_scl = 1'b0;
              seq_sda = 1'b1;
              seq_end(i2cbb_pkg::ST_OK);
            end else begin
              seq_enter(3'd0, 1'b0, 1'b1);
            end
          end
        end
        default: seq_end(i2cbb_pkg::ST_OK);
      endcase
    end
    r.scl_out = seq_scl;
    r.sda_out = seq_sda;
    r.busy_res = (seq_op != i2cbb_pkg::CMD_NONE);
    r.done_res = seq_done;
    r.rx_byte = seq_rx;
    r.status = seq_done ? seq_status : i2cbb_pkg::ST_OK;
    return r;
  endfunction

  // SDA level for the next tick, as the bus and the slave would show it
  function automatic logic bus_sda(bus_mode_t mode);
    logic v;
    case (mode)
      BUS_LOW: v = 1'b0;
      BUS_HIGH: v = 1'b1;
      BUS_RAND: v = 1'($urandom_range(0, 1));
      default: begin
        if (seq_op == i2cbb_pkg::CMD_WACK) begin
          v = (slave_delay != 8'd0);
          if (seq_phase == 3'd2 && v && slave_delay != 8'd255) slave_delay--;
        end else if (seq_op == i2cbb_pkg::CMD_READ) begin
          v = 1'($urandom_range(0, 1));
        end else begin
          v = seq_sda;
        end
        // occasional glitch on a noisy bus
        if (mode == BUS_NOISY && $urandom_range(0, 31) == 0) v = ~v;
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Result channel: receiver stalls and checking
  // ---------------------------------------------------------------------------
  initial begin
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off so the block fills and stalls its input
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        res_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        res_ready <= 1'b1;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin
    i2cbb_pkg::res_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_drive.size() == 0) begin
        $error("result transaction with nothing expected");
        n_fail++;
      end else begin
        want = pending_drive.pop_front();
        check_field("scl_out", 8'(want.scl_out), 8'(res.scl_out));
        check_field("sda_out", 8'(want.sda_out), 8'(res.sda_out));
        check_field("busy_res", 8'(want.busy_res), 8'(res.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(res.done_res));
        check_field("rx_byte", want.rx_byte, res.rx_byte);
        check_field("status", 8'(want.status), 8'(res.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command channel
  // ---------------------------------------------------------------------------
  // Offer one tick, hold until accepted, then maybe idle for a burst
  task automatic drive_tick(i2cbb_pkg::cmd_item_t item);
    cmd_valid <= 1'b1;
    cmd <= item;
    do @(posedge clk); while (!cmd_ready);
    pending_drive.push_back(i2c_tick(item));
    n_ticks++;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Issue one command, then tick until the sequencer is idle again;
  // stray commands on busy ticks must be ignored
  task automatic run_cmd(i2cbb_pkg::cmd_t f, logic [7:0] tx, logic msb, bus_mode_t mode);
    i2cbb_pkg::cmd_item_t item;
    if (f == i2cbb_pkg::CMD_WACK) begin
      slave_delay = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 4));
    end
    item.func = f;
    item.tx_byte = tx;
    item.msb_first = msb;
    item.sda_in = bus_sda(mode);
    drive_tick(item);
    while (seq_op != i2cbb_pkg::CMD_NONE) begin
      item.func = ($urandom_range(0, 7) == 0) ? i2cbb_pkg::cmd_t'($urandom_range(1, 7))
                                             : i2cbb_pkg::CMD_NONE;
      item.tx_byte = 8'($urandom);
      item.msb_first = 1'($urandom_range(0, 1));
      item.sda_in = bus_sda(mode);
      drive_tick(item);
    end
  endtask

  // Drop valid and wait until every result is back
  task automatic settle();
    cmd_valid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [i2cbb_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == i2cbb_pkg::REG_PHASE_TICKS) cfg_ticks = val;
    else cfg_timeout = val;
  endtask

  // One bus transfer: start, address, then data bytes, then stop; at times random commands instead
  task automatic i2c_transfer();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        run_cmd(i2cbb_pkg::cmd_t'($urandom_range(0, 7)), 8'($urandom),
                1'($urandom_range(0, 1)), BUS_RAND);
      end
    end else begin
      run_cmd(i2cbb_pkg::CMD_START, 8'($urandom), 1'($urandom_range(0, 1)), BUS_NOISY);
      run_cmd(i2cbb_pkg::CMD_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), BUS_NOISY);
      run_cmd(i2cbb_pkg::CMD_WACK, 8'($urandom), 1'($urandom_range(0, 1)), BUS_NOISY);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 1)) begin
          run_cmd(i2cbb_pkg::CMD_WRITE, 8'($urandom), 1'($urandom_range(0, 1)),
                  BUS_NOISY);
          run_cmd(i2cbb_pkg::CMD_WACK, 8'($urandom), 1'($urandom_range(0, 1)),
                  BUS_NOISY);
        end else begin
          run_cmd(i2cbb_pkg::CMD_READ, 8'($urandom), 1'($urandom_range(0, 1)),
                  BUS_NOISY);
          run_cmd($urandom_range(0, 1) ? i2cbb_pkg::CMD_ACK : i2cbb_pkg::CMD_NACK,
                  8'($urandom), 1'($urandom_range(0, 1)), BUS_NOISY);
        end
      end
      run_cmd(i2cbb_pkg::CMD_STOP, 8'($urandom), 1'($urandom_range(0, 1)), BUS_NOISY);
    end
    if ($urandom_range(0, 3) == 0) begin
      run_cmd(i2cbb_pkg::CMD_NONE, 8'($urandom), 1'($urandom_range(0, 1)), BUS_RAND);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_state();
    repeat (4) begin
      run_cmd(i2cbb_pkg::CMD_NONE, 8'($urandom), 1'($urandom_range(0, 1)), BUS_RAND);
    end
  endtask

  task automatic test_each_command();
    run_cmd(i2cbb_pkg::CMD_START, 8'h00, 1'b0, BUS_LOOP);
    // short phases for the rest of the command walk
    write_reg(i2cbb_pkg::REG_PHASE_TICKS, 8'd1);
    run_cmd(i2cbb_pkg::CMD_WRITE, 8'hA5, 1'b1, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_WACK, 8'h00, 1'b0, BUS_LOW);
    run_cmd(i2cbb_pkg::CMD_WRITE, 8'h3C, 1'b0, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_WACK, 8'hFF, 1'b1, BUS_HIGH);
    run_cmd(i2cbb_pkg::CMD_WRITE, 8'hFF, 1'b1, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_WRITE, 8'h00, 1'b0, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_WRITE, 8'h80, 1'b0, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_WRITE, 8'h01, 1'b1, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_READ, 8'h00, 1'b0, BUS_HIGH);
    run_cmd(i2cbb_pkg::CMD_READ, 8'hFF, 1'b1, BUS_LOW);
    run_cmd(i2cbb_pkg::CMD_READ, 8'h5A, 1'b0, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_ACK, 8'h00, 1'b1, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_NACK, 8'hFF, 1'b0, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_STOP, 8'h00, 1'b0, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_START, 8'h00, 1'b0, BUS_LOW);
    run_cmd(i2cbb_pkg::CMD_START, 8'hFF, 1'b1, BUS_HIGH);
    run_cmd(i2cbb_pkg::CMD_START, 8'h00, 1'b0, BUS_RAND);
    run_cmd(i2cbb_pkg::CMD_STOP, 8'h00, 1'b0, BUS_LOOP);
  endtask

  task automatic test_register_extremes();
    // longest phase; a busy bus ends the start after one phase
    write_reg(i2cbb_pkg::REG_PHASE_TICKS, 8'd255);
    run_cmd(i2cbb_pkg::CMD_START, 8'h00, 1'b1, BUS_LOW);
    // zero acts as one
    write_reg(i2cbb_pkg::REG_PHASE_TICKS, 8'd0);
    run_cmd(i2cbb_pkg::CMD_ACK, 8'h00, 1'b0, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_WRITE, 8'h5A, 1'b1, BUS_LOOP);
    write_reg(i2cbb_pkg::REG_ACK_TIMEOUT, 8'd0);
    run_cmd(i2cbb_pkg::CMD_WACK, 8'h00, 1'b0, BUS_HIGH);
    write_reg(i2cbb_pkg::REG_ACK_TIMEOUT, 8'd1);
    run_cmd(i2cbb_pkg::CMD_WACK, 8'h00, 1'b0, BUS_HIGH);
    run_cmd(i2cbb_pkg::CMD_WACK, 8'h00, 1'b0, BUS_LOW);
    write_reg(i2cbb_pkg::REG_ACK_TIMEOUT, 8'd255);
    write_reg(i2cbb_pkg::REG_PHASE_TICKS, 8'd1);
    run_cmd(i2cbb_pkg::CMD_READ, 8'h00, 1'b0, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_STOP, 8'h00, 1'b0, BUS_LOOP);
  endtask

  task automatic test_input_stall();
    write_reg(i2cbb_pkg::REG_ACK_TIMEOUT, 8'd4);
    hold_req = 1'b1;
    run_cmd(i2cbb_pkg::CMD_START, 8'($urandom), 1'b0, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_WRITE, 8'($urandom), 1'b1, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_WACK, 8'($urandom), 1'b0, BUS_LOOP);
    run_cmd(i2cbb_pkg::CMD_STOP, 8'($urandom), 1'b0, BUS_LOOP);
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    for (int seg = 0; seg < 4; seg++) begin
      write_reg(i2cbb_pkg::REG_PHASE_TICKS, 8'($urandom_range(1, 2)));
      write_reg(i2cbb_pkg::REG_ACK_TIMEOUT, 8'($urandom_range(1, 6)));
      // no idling on either side in the last stretch
      if (seg == 3) idle_en = 1'b0;
      target = n_ticks + 30;
      while (n_ticks < target) i2c_transfer();
    end
  endtask

  initial begin
    model_reset();
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_each_command();
    test_register_extremes();
    test_input_stall();
    test_random_traffic();

    settle();
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
